// ===== hw/rtl/rng_pkg.sv =====
// ----------------------------------------------------------------------------
// rng_pkg
// shared types, register codes and helpers of the ultrasonic echo ranger
// ----------------------------------------------------------------------------
package rng_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_SCALE_Q16       = 3'd0;
  localparam logic [2:0] CFG_MAX_DISTANCE    = 3'd1;
  localparam logic [2:0] CFG_ALARM_THRESHOLD = 3'd2;
  localparam logic [2:0] CFG_TIMEOUT_TICKS   = 3'd3;
  localparam logic [2:0] CFG_TRIGGER_TICKS   = 3'd4;

  // register reset values
  localparam logic [15:0] SCALE_Q16_RST       = 16'd11452;
  localparam logic [13:0] MAX_DISTANCE_RST    = 14'd4000;
  localparam logic [13:0] ALARM_THRESHOLD_RST = 14'd1000;
  localparam logic [15:0] TIMEOUT_TICKS_RST   = 16'd18000;
  localparam logic [7:0]  TRIGGER_TICKS_RST   = 8'd10;

  // largest distance that still fits four digits
  localparam logic [15:0] RANGE_LIMIT = 16'd9999;

  // how a tick ends the measurement, if at all
  typedef enum logic [1:0] {
    FIN_NONE    = 2'd0,
    FIN_MEAS    = 2'd1,
    FIN_TIMEOUT = 2'd2
  } rng_fin_t;

  // classified tick, front to back
  typedef struct packed {
    logic        trig;
    logic        done;
    logic        busy;
    rng_fin_t    fin;
    logic [15:0] ticks;
  } rng_evt_t;

  // one full result
  typedef struct packed {
    logic        trigger;
    logic        done_res;
    logic        busy_res;
    logic [13:0] range_mm;
    logic [3:0]  digit_thousands;
    logic [3:0]  digit_hundreds;
    logic [3:0]  digit_tens;
    logic [3:0]  digit_ones;
    logic        alarm;
    logic        timed_out;
  } rng_res_t;

  // one decimal digit and what is left below it
  typedef struct packed {
    logic [3:0]  digit;
    logic [13:0] rest;
  } rng_dig_t;

  // value below ten units: digit by parallel compares, then one subtract
  function automatic rng_dig_t dec_split(input logic [13:0] value,
                                         input logic [13:0] unit);
    rng_dig_t d;
    d.digit = '0;
    for (int k = 1; k < 10; k++) begin
      if (value >= 14'(k) * unit) begin
        d.digit = 4'(k);
      end
    end
    d.rest = value - 14'(d.digit) * unit;
    return d;
  endfunction

endpackage

// ===== hw/rtl/rng_ifs.sv =====
// ----------------------------------------------------------------------------
// rng_ifs
// valid/ready channels for input ticks and results
// ----------------------------------------------------------------------------
interface rng_tick_if;
  logic valid;
  logic ready;
  logic start_req;
  logic echo;

  modport source (output valid, start_req, echo, input ready);
  modport sink   (input valid, start_req, echo, output ready);
endinterface

interface rng_res_if;
  logic        valid;
  logic        ready;
  logic        trigger;
  logic        done_res;
  logic        busy_res;
  logic [13:0] range_mm;
  logic [3:0]  digit_thousands;
  logic [3:0]  digit_hundreds;
  logic [3:0]  digit_tens;
  logic [3:0]  digit_ones;
  logic        alarm;
  logic        timed_out;

  modport source (output valid, trigger, done_res, busy_res, range_mm, digit_thousands,
                  digit_hundreds, digit_tens, digit_ones, alarm, timed_out,
                  input ready);
  modport sink   (input valid, trigger, done_res, busy_res, range_mm, digit_thousands,
                  digit_hundreds, digit_tens, digit_ones, alarm, timed_out,
                  output ready);
endinterface

// ===== hw/rtl/rng_front.sv =====
// ----------------------------------------------------------------------------
// rng_front
// measurement sequencer: takes ticks and classifies each into an event
// ----------------------------------------------------------------------------
module rng_front (
  input  logic               clk,
  input  logic               rst,
  rng_tick_if.sink           tick,
  input  logic [7:0]         trigger_ticks,
  input  logic [15:0]        timeout_ticks,
  input  logic               push_ready,
  output logic               push,
  output rng_pkg::rng_evt_t  evt
);

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_TRIG = 4'b0010,
    PH_WAIT = 4'b0100,
    PH_HIGH = 4'b1000
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] tick_count, tick_count_next;
  logic [15:0] count_inc;

  assign tick.ready = push_ready;
  assign push       = tick.valid && push_ready;
  assign count_inc  = tick_count + 16'd1;

  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    evt.trig        = 1'b0;
    evt.fin         = rng_pkg::FIN_NONE;
    evt.ticks       = tick_count;
    case (phase)
      PH_IDLE: begin
        if (tick.start_req) begin
          phase_next      = PH_TRIG;
          tick_count_next = '0;
        end
      end
      PH_TRIG: begin
        evt.trig = 1'b1;
        if (count_inc >= {8'd0, trigger_ticks}) begin
          phase_next      = PH_WAIT;
          tick_count_next = '0;
        end else begin
          tick_count_next = count_inc;
        end
      end
      PH_WAIT: begin
        if (tick.echo) begin
          if (timeout_ticks <= 16'd1) begin
            evt.fin         = rng_pkg::FIN_TIMEOUT;
            evt.ticks       = 16'd1;
            phase_next      = PH_IDLE;
            tick_count_next = '0;
          end else begin
            phase_next      = PH_HIGH;
            tick_count_next = 16'd1;
          end
        end
      end
      PH_HIGH: begin
        if (tick.echo) begin
          if (count_inc >= timeout_ticks) begin
            evt.fin         = rng_pkg::FIN_TIMEOUT;
            evt.ticks       = count_inc;
            phase_next      = PH_IDLE;
            tick_count_next = '0;
          end else begin
            tick_count_next = count_inc;
          end
        end else begin
          // falling edge: measure the ticks counted so far
          evt.fin         = rng_pkg::FIN_MEAS;
          phase_next      = PH_IDLE;
          tick_count_next = '0;
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        tick_count_next = '0;
      end
    endcase
    evt.done = (evt.fin != rng_pkg::FIN_NONE);
    evt.busy = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= '0;
    end else if (push) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    push && evt.done |-> !evt.busy && !evt.trig)
    else $error("finishing tick leaves the sequencer busy");

  assert property (@(posedge clk) disable iff (rst)
    push && evt.trig |-> evt.busy)
    else $error("trigger tick reports idle");

endmodule

// ===== hw/rtl/rng_queue.sv =====
// ----------------------------------------------------------------------------
// rng_queue
// short event queue between sequencer and arithmetic pipeline
// ----------------------------------------------------------------------------
module rng_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  rng_pkg::rng_evt_t  push_data,
  output logic               push_ready,
  input  logic               pop,
  output logic               pop_valid,
  output rng_pkg::rng_evt_t  pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rng_pkg::rng_evt_t slots [DEPTH];
  logic [PW-1:0]     wr_ptr, rd_ptr;
  logic [CW-1:0]     count;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    !(push && !push_ready) && !(pop && !pop_valid))
    else $error("queue overflow or underflow");

endmodule

// ===== hw/rtl/rng_back.sv =====
// ----------------------------------------------------------------------------
// rng_back
// arithmetic pipeline: distance, limit and alarm, then decimal digits
// ----------------------------------------------------------------------------
module rng_back (
  input  logic               clk,
  input  logic               rst,
  input  logic [15:0]        scale_q16,
  input  logic [13:0]        max_distance,
  input  logic [13:0]        alarm_threshold,
  input  logic               q_valid,
  input  rng_pkg::rng_evt_t  q_data,
  output logic               q_pop,
  rng_res_if.source          res
);

  logic               advance;
  logic               v1, v2, v3, v4, v5;
  rng_pkg::rng_evt_t  e1;
  logic [31:0]        prod1;
  rng_pkg::rng_res_t  r2, r3, r4, r5;
  rng_pkg::rng_res_t  r3_next, r4_next, r5_next;
  logic [13:0]        rem3, rem4;

  logic [13:0]        last_range, last_range_next;
  logic               alarm_flag, alarm_flag_next;
  logic               timeout_flag, timeout_flag_next;
  logic [15:0]        meas_mm;
  logic [13:0]        dist_ok;
  rng_pkg::rng_dig_t  sp3, sp4, sp5;

  assign advance = !v5 || res.ready;
  assign q_pop   = advance && q_valid;

  // limit and alarm of the finishing measurement
  assign meas_mm = prod1[31:16];
  assign dist_ok = (meas_mm > {2'd0, max_distance} || meas_mm > rng_pkg::RANGE_LIMIT)
                 ? '0 : meas_mm[13:0];

  always_comb begin
    last_range_next   = last_range;
    alarm_flag_next   = alarm_flag;
    timeout_flag_next = timeout_flag;
    case (e1.fin)
      rng_pkg::FIN_MEAS: begin
        last_range_next   = dist_ok;
        alarm_flag_next   = (dist_ok > alarm_threshold);
        timeout_flag_next = 1'b0;
      end
      rng_pkg::FIN_TIMEOUT: begin
        last_range_next   = '0;
        alarm_flag_next   = 1'b0;
        timeout_flag_next = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign sp3 = rng_pkg::dec_split(r2.range_mm, 14'd1000);
  assign sp4 = rng_pkg::dec_split(rem3, 14'd100);
  assign sp5 = rng_pkg::dec_split(rem4, 14'd10);

  // each digit stage passes the result on with one more digit filled in; the last stage fills in both tens and ones
  always_comb begin
    r3_next                 = r2;
    r3_next.digit_thousands = sp3.digit;
    r4_next                 = r3;
    r4_next.digit_hundreds  = sp4.digit;
    r5_next                 = r4;
    r5_next.digit_tens      = sp5.digit;
    r5_next.digit_ones      = sp5.rest[3:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      v5           <= 1'b0;
      last_range   <= '0;
      alarm_flag   <= 1'b0;
      timeout_flag <= 1'b0;
    end else if (advance) begin
      v1 <= q_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      if (v1) begin
        last_range   <= last_range_next;
        alarm_flag   <= alarm_flag_next;
        timeout_flag <= timeout_flag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      e1    <= q_data;
      prod1 <= 32'(q_data.ticks) * 32'(scale_q16);

      r2.trigger         <= e1.trig;
      r2.done_res        <= e1.done;
      r2.busy_res        <= e1.busy;
      r2.range_mm        <= last_range_next;
      r2.digit_thousands <= '0;
      r2.digit_hundreds  <= '0;
      r2.digit_tens      <= '0;
      r2.digit_ones      <= '0;
      r2.alarm           <= alarm_flag_next;
      r2.timed_out       <= timeout_flag_next;

      r3   <= r3_next;
      rem3 <= sp3.rest;

      r4   <= r4_next;
      rem4 <= sp4.rest;

      r5   <= r5_next;
    end
  end

  assign res.valid           = v5;
  assign res.trigger         = r5.trigger;
  assign res.done_res        = r5.done_res;
  assign res.busy_res        = r5.busy_res;
  assign res.range_mm        = r5.range_mm;
  assign res.digit_thousands = r5.digit_thousands;
  assign res.digit_hundreds  = r5.digit_hundreds;
  assign res.digit_tens      = r5.digit_tens;
  assign res.digit_ones      = r5.digit_ones;
  assign res.alarm           = r5.alarm;
  assign res.timed_out       = r5.timed_out;

  assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (14'(res.digit_thousands) * 14'd1000 + 14'(res.digit_hundreds) * 14'd100
                   + 14'(res.digit_tens) * 14'd10 + 14'(res.digit_ones)) == res.range_mm)
    else $error("decimal digits disagree with range");

  assert property (@(posedge clk) disable iff (rst)
    res.valid && res.timed_out |-> res.range_mm == '0 && !res.alarm)
    else $error("timed out result carries a distance or alarm");

endmodule

// ===== hw/rtl/ultrasonic_echo_ranger.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// path: a tick's request is written into the queue when it is taken, then its
//   result passes through 5 pipeline stages; a full queue or a stalled
//   receiver holds it back
// throughput: one tick request per cycle while the queue has room
// reset: rst clears sequencer, queue, pipeline valids and last result, and
//   loads the register defaults
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  rng_tick_if.sink    tick,
  rng_res_if.source   res,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  // configuration registers
  logic [15:0] scale_q16;
  logic [13:0] max_distance;
  logic [13:0] alarm_threshold;
  logic [15:0] timeout_ticks;
  logic [7:0]  trigger_ticks;

  // front to queue
  logic              push, push_ready;
  rng_pkg::rng_evt_t push_data;

  // queue to back
  logic              pop, pop_valid;
  rng_pkg::rng_evt_t pop_data;

  // register writes, indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_q16       <= rng_pkg::SCALE_Q16_RST;
      max_distance    <= rng_pkg::MAX_DISTANCE_RST;
      alarm_threshold <= rng_pkg::ALARM_THRESHOLD_RST;
      timeout_ticks   <= rng_pkg::TIMEOUT_TICKS_RST;
      trigger_ticks   <= rng_pkg::TRIGGER_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rng_pkg::CFG_SCALE_Q16:       scale_q16       <= cfg_wdata;
        rng_pkg::CFG_MAX_DISTANCE:    max_distance    <= cfg_wdata[13:0];
        rng_pkg::CFG_ALARM_THRESHOLD: alarm_threshold <= cfg_wdata[13:0];
        rng_pkg::CFG_TIMEOUT_TICKS:   timeout_ticks   <= cfg_wdata;
        rng_pkg::CFG_TRIGGER_TICKS:   trigger_ticks   <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer: one tick per cycle while the queue has room, turns each request into an event
  rng_front u_front (
    .clk           (clk),
    .rst           (rst),
    .tick          (tick),
    .trigger_ticks (trigger_ticks),
    .timeout_ticks (timeout_ticks),
    .push_ready    (push_ready),
    .push          (push),
    .evt           (push_data)
  );

  // decouples the sequencer from result back-pressure
  rng_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data)
  );

  // multiply, range limit, alarm, last-result hold and digit split
  rng_back u_back (
    .clk             (clk),
    .rst             (rst),
    .scale_q16       (scale_q16),
    .max_distance    (max_distance),
    .alarm_threshold (alarm_threshold),
    .q_valid         (pop_valid),
    .q_data          (pop_data),
    .q_pop           (pop),
    .res             (res)
  );

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the ultrasonic echo ranger: a queue-fed driver
// offers tick requests with random gaps, a scoreboard model predicts the
// result of every accepted tick, and a monitor compares each result field
// by field while the receiver stalls at random; register settings change
// between phases while the block is idle
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // one tick request as the driver sees it
  typedef struct packed {
    logic start_req;
    logic echo;
  } tick_req_t;

  // sequencer phases of the scoreboard model
  typedef enum logic [1:0] {
    RG_IDLE = 2'd0,
    RG_TRIG = 2'd1,
    RG_WAIT = 2'd2,
    RG_HIGH = 2'd3
  } ranger_phase_t;

  localparam int WATCHDOG_CYCLES = 5000;
  localparam int LONG_HOLD       = 300;
  localparam int DRAIN_CYCLES    = 8;

  // clock, reset and every block input start at known values
  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        cfg_we     = 1'b0;
  logic [2:0]  cfg_index  = rng_pkg::CFG_SCALE_Q16;
  logic [15:0] cfg_wdata  = '0;
  logic        src_valid  = 1'b0;
  logic        src_start  = 1'b0;
  logic        src_echo   = 1'b0;
  logic        snk_ready  = 1'b0;

  rng_tick_if tick_ch ();
  rng_res_if  res_ch ();

  assign tick_ch.valid     = src_valid;
  assign tick_ch.start_req = src_start;
  assign tick_ch.echo      = src_echo;
  assign res_ch.ready      = snk_ready;

  ultrasonic_echo_ranger u_dut (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // pending tick requests and the results they are expected to give
  tick_req_t          pend_ticks[$];
  rng_pkg::rng_res_t  range_expected[$];

  int pushed_ticks = 0;
  int fail_count   = 0;
  int result_idx   = 0;
  bit no_idle      = 1'b0;
  int hold_reqs    = 0;

  // model copy of the registers
  logic [15:0] scale_r;
  logic [13:0] maxd_r;
  logic [13:0] thr_r;
  logic [15:0] tmo_r;
  logic [7:0]  trg_r;

  // model copy of the ranger state
  ranger_phase_t ph;
  logic [15:0]   tick_cnt;
  logic [13:0]   last_mm;
  logic          alarm_q;
  logic          tmo_q;

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s: got %0d, expected %0d (result %0d)", what, got, want,
             result_idx);
    fail_count++;
  endtask

  // --------------------------------------------------------------------------
  // scoreboard model
  // --------------------------------------------------------------------------

  // ends a measurement: either abandoned on timeout or converted to mm
  function automatic void close_measurement(input logic hit_timeout);
    logic [31:0] dist_mm;
    if (hit_timeout) begin
      last_mm = '0;
      alarm_q = 1'b0;
      tmo_q   = 1'b1;
    end else begin
      dist_mm = (32'(tick_cnt) * 32'(scale_r)) >> 16;
      // too far for the limit or for four digits reads as zero
      if (dist_mm > 32'(maxd_r) || dist_mm > 32'(rng_pkg::RANGE_LIMIT)) begin
        dist_mm = '0;
      end
      last_mm = dist_mm[13:0];
      alarm_q = (dist_mm > 32'(thr_r));
      tmo_q   = 1'b0;
    end
    ph       = RG_IDLE;
    tick_cnt = '0;
  endfunction

  // advances the model by one tick and returns the result it gives
  function automatic rng_pkg::rng_res_t advance_ranger(input logic start,
                                                       input logic echo_lvl);
    rng_pkg::rng_res_t r;
    logic     trig;
    logic     done;
    trig = 1'b0;
    done = 1'b0;
    case (ph)
      RG_IDLE: begin
        if (start) begin
          ph       = RG_TRIG;
          tick_cnt = '0;
        end
      end
      RG_TRIG: begin
        // a zero pulse length still gives one trigger tick
        trig     = 1'b1;
        tick_cnt = tick_cnt + 16'd1;
        if (tick_cnt >= 16'(trg_r)) begin
          ph       = RG_WAIT;
          tick_cnt = '0;
        end
      end
      RG_WAIT: begin
        // no timeout before the rising edge, the first high tick counts as one
        if (echo_lvl) begin
          ph       = RG_HIGH;
          tick_cnt = 16'd1;
          if (tick_cnt >= tmo_r) begin
            close_measurement(1'b1);
            done = 1'b1;
          end
        end
      end
      default: begin
        if (echo_lvl) begin
          tick_cnt = tick_cnt + 16'd1;
          if (tick_cnt >= tmo_r) begin
            close_measurement(1'b1);
            done = 1'b1;
          end
        end else begin
          close_measurement(1'b0);
          done = 1'b1;
        end
      end
    endcase
    r.trigger         = trig;
    r.done_res        = done;
    r.busy_res        = (ph != RG_IDLE);
    r.range_mm        = last_mm;
    r.digit_thousands = 4'(last_mm / 1000 % 10);
    r.digit_hundreds  = 4'(last_mm / 100 % 10);
    r.digit_tens      = 4'(last_mm / 10 % 10);
    r.digit_ones      = 4'(last_mm % 10);
    r.alarm           = alarm_q;
    r.timed_out       = tmo_q;
    return r;
  endfunction

  // every accepted tick request gives exactly one expected result
  always @(posedge clk) begin
    if (!rst && src_valid && tick_ch.ready) begin
      range_expected.push_back(advance_ranger(src_start, src_echo));
    end
  end

  // --------------------------------------------------------------------------
  // driver and receiver
  // --------------------------------------------------------------------------

  // mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  int        src_gap = 0;
  tick_req_t nxt_tick;

  // offers the next pending request once the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      src_valid <= 1'b0;
      src_gap = 0;
    end else if (!src_valid || tick_ch.ready) begin
      if (src_gap > 0) begin
        src_valid <= 1'b0;
        src_gap--;
      end else if (pend_ticks.size() != 0) begin
        nxt_tick = pend_ticks.pop_front();
        src_valid <= 1'b1;
        src_start <= nxt_tick.start_req;
        src_echo  <= nxt_tick.echo;
        src_gap = no_idle ? 0 : pick_gap();
      end else begin
        src_valid <= 1'b0;
      end
    end
  end

  int snk_gap   = 0;
  int hold_left = 0;
  int hold_seen = 0;

  // random stalls on the result side, plus one long hold on request
  always @(posedge clk) begin
    if (rst) begin
      snk_ready <= 1'b0;
    end else if (hold_left > 0) begin
      snk_ready <= 1'b0;
      hold_left--;
    end else if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = LONG_HOLD;
      snk_ready <= 1'b0;
    end else if (snk_gap > 0) begin
      snk_ready <= 1'b0;
      snk_gap--;
    end else begin
      snk_ready <= 1'b1;
      if (!no_idle && $urandom_range(0, 3) == 0) begin
        snk_gap = pick_gap();
      end
    end
  end

  // --------------------------------------------------------------------------
  // result monitor
  // --------------------------------------------------------------------------
  rng_pkg::rng_res_t want;

  always @(posedge clk) begin
    if (!rst && res_ch.valid && snk_ready) begin
      if (range_expected.size() == 0) begin
        flag_mismatch("result with nothing expected", 0, 0);
      end else begin
        want = range_expected.pop_front();
        if (res_ch.trigger !== want.trigger)
          flag_mismatch("trigger", res_ch.trigger, want.trigger);
        if (res_ch.done_res !== want.done_res)
          flag_mismatch("done_res", res_ch.done_res, want.done_res);
        if (res_ch.busy_res !== want.busy_res)
          flag_mismatch("busy_res", res_ch.busy_res, want.busy_res);
        if (res_ch.range_mm !== want.range_mm)
          flag_mismatch("range_mm", res_ch.range_mm, want.range_mm);
        if (res_ch.digit_thousands !== want.digit_thousands)
          flag_mismatch("digit_thousands", res_ch.digit_thousands, want.digit_thousands);
        if (res_ch.digit_hundreds !== want.digit_hundreds)
          flag_mismatch("digit_hundreds", res_ch.digit_hundreds, want.digit_hundreds);
        if (res_ch.digit_tens !== want.digit_tens)
          flag_mismatch("digit_tens", res_ch.digit_tens, want.digit_tens);
        if (res_ch.digit_ones !== want.digit_ones)
          flag_mismatch("digit_ones", res_ch.digit_ones, want.digit_ones);
        if (res_ch.alarm !== want.alarm)
          flag_mismatch("alarm", res_ch.alarm, want.alarm);
        if (res_ch.timed_out !== want.timed_out)
          flag_mismatch("timed_out", res_ch.timed_out, want.timed_out);
      end
      result_idx++;
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: too long without any request or result moving
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (src_valid && tick_ch.ready) || (res_ch.valid && snk_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("timeout: nothing moved for %0d cycles", quiet_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  task automatic push_tick(input logic s, input logic e);
    tick_req_t t;
    t.start_req = s;
    t.echo      = e;
    pend_ticks.push_back(t);
    pushed_ticks++;
  endtask

  // one well-formed measurement for the current settings; start requests
  // are sprinkled only where the block must ignore them
  task automatic push_measurement(input int wait_len, input int high_len,
                                  input bit start_noise);
    int trig_len;
    bit times_out;
    trig_len  = (trg_r == 0) ? 1 : int'(trg_r);
    times_out = (high_len >= int'(tmo_r));
    push_tick(1'b1, 1'($urandom_range(0, 1)));
    repeat (trig_len) push_tick(start_noise & 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)));
    repeat (wait_len) push_tick(start_noise & 1'($urandom_range(0, 1)), 1'b0);
    repeat (high_len) push_tick(1'b0, 1'b1);
    // start on the finishing tick is ignored, unless a timeout ended it earlier
    push_tick(!times_out & start_noise & 1'($urandom_range(0, 1)), 1'b0);
  endtask

  // brings the block back to idle from any phase
  task automatic push_settle();
    int trig_len;
    trig_len = (trg_r == 0) ? 1 : int'(trg_r);
    repeat (trig_len + 1) push_tick(1'b0, 1'b0);
    push_tick(1'b0, 1'b1);
    push_tick(1'b0, 1'b0);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pend_ticks.size() != 0 || src_valid || range_expected.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      rng_pkg::CFG_SCALE_Q16:       scale_r = val;
      rng_pkg::CFG_MAX_DISTANCE:    maxd_r  = val[13:0];
      rng_pkg::CFG_ALARM_THRESHOLD: thr_r   = val[13:0];
      rng_pkg::CFG_TIMEOUT_TICKS:   tmo_r   = val;
      rng_pkg::CFG_TRIGGER_TICKS:   trg_r   = val[7:0];
      default: ;
    endcase
  endtask

  task automatic write_regs(input logic [15:0] scale, input logic [15:0] maxd,
                            input logic [15:0] thr, input logic [15:0] tmo,
                            input logic [15:0] trg);
    write_reg(rng_pkg::CFG_SCALE_Q16, scale);
    write_reg(rng_pkg::CFG_MAX_DISTANCE, maxd);
    write_reg(rng_pkg::CFG_ALARM_THRESHOLD, thr);
    write_reg(rng_pkg::CFG_TIMEOUT_TICKS, tmo);
    write_reg(rng_pkg::CFG_TRIGGER_TICKS, trg);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // random settings, mostly sized so that short echoes reach the limits
  task automatic randomize_regs();
    logic [15:0] scale;
    logic [15:0] maxd;
    logic [15:0] thr;
    logic [15:0] tmo;
    logic [15:0] trg;
    case ($urandom_range(0, 2))
      0:       scale = 16'($urandom_range(0, 65535));
      1:       scale = 16'($urandom_range(60000, 65535));
      default: scale = 16'($urandom_range(0, 3000));
    endcase
    maxd = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 16383))
                                       : 16'($urandom_range(0, 60));
    thr  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 16383))
                                       : 16'($urandom_range(0, 60));
    tmo  = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
                                       : 16'($urandom_range(0, 50));
    trg  = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 255))
                                       : 16'($urandom_range(0, 6));
    write_regs(scale, maxd, thr, tmo, trg);
  endtask

  // mostly well-formed measurements, the rest random noise followed by a settle
  task automatic run_random_phase(input int quota);
    int first;
    int w;
    int h;
    first = pushed_ticks;
    while (pushed_ticks - first < quota) begin
      if ($urandom_range(0, 9) < 8) begin
        w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 4);
        if ($urandom_range(0, 3) == 0 && tmo_r > 0 && tmo_r < 100) begin
          // land right around the timeout
          h = $urandom_range((tmo_r > 1) ? int'(tmo_r) - 1 : 1, int'(tmo_r) + 1);
        end else begin
          h = $urandom_range(1, 40);
        end
        push_measurement(w, h, 1'($urandom_range(0, 1)));
      end else begin
        repeat ($urandom_range(3, 15)) begin
          push_tick(($urandom_range(0, 2) == 0), 1'($urandom_range(0, 1)));
        end
        push_settle();
      end
    end
  endtask

  initial begin
    int p;

    // model starts from the register defaults and an idle sequencer
    scale_r  = rng_pkg::SCALE_Q16_RST;
    maxd_r   = rng_pkg::MAX_DISTANCE_RST;
    thr_r    = rng_pkg::ALARM_THRESHOLD_RST;
    tmo_r    = rng_pkg::TIMEOUT_TICKS_RST;
    trg_r    = rng_pkg::TRIGGER_TICKS_RST;
    ph       = RG_IDLE;
    tick_cnt = '0;
    last_mm  = '0;
    alarm_q  = 1'b0;
    tmo_q    = 1'b0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // defaults: echo in idle ignored, start taken with echo high, start
    // ignored all through the measurement and on its finishing tick
    push_tick(1'b0, 1'b1);
    push_tick(1'b1, 1'b1);
    repeat (10) push_tick(1'b1, 1'b1);
    repeat (2) push_tick(1'b1, 1'b0);
    repeat (3) push_tick(1'b0, 1'b1);
    push_tick(1'b1, 1'b0);
    push_tick(1'b0, 1'b0);
    wait_drained();

    // about one mm per tick, short pulse: smallest distances and the alarm
    write_regs(16'd65535, 16'd9999, 16'd20, 16'd65535, 16'd1);
    push_measurement(0, 1, 1'b1);
    push_measurement(1, 2, 1'b0);
    push_measurement(2, 30, 1'b1);
    wait_drained();

    // distance right at the limit, then one tick more reads as zero
    write_regs(16'd65535, 16'd40, 16'd30, 16'd65535, 16'd1);
    push_measurement(0, 41, 1'b0);
    push_measurement(0, 42, 1'b0);
    wait_drained();

    // zero pulse length and zero timeout; a long wait for the echo to rise
    write_regs(16'd65535, 16'd100, 16'd0, 16'd0, 16'd0);
    push_measurement(30, 3, 1'b1);
    wait_drained();
    write_regs(16'd65535, 16'd100, 16'd0, 16'd1, 16'd40);
    push_measurement(2, 1, 1'b1);
    wait_drained();

    // zero scale, limit and threshold
    write_regs(16'd0, 16'd0, 16'd0, 16'd40, 16'd2);
    push_measurement(1, 5, 1'b0);
    wait_drained();

    // random part over several settings
    for (p = 0; p < 8; p++) begin
      randomize_regs();
      no_idle = (p == 2);
      run_random_phase(25);
      // sender keeps offering while results are held back
      if (p == 5) hold_reqs++;
      wait_drained();
      no_idle = 1'b0;
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && range_expected.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/rng_pkg.sv
hw/rtl/rng_ifs.sv
hw/rtl/rng_front.sv
hw/rtl/rng_queue.sv
hw/rtl/rng_back.sv
hw/rtl/ultrasonic_echo_ranger.sv
bench/tb.sv
